// ===== hdl/vae_pkg.sv =====
// ----------------------------------------------------------------------------
// vae_pkg
// Shared types and constants for the vertical arc elevation evaluator.
// ----------------------------------------------------------------------------
package vae_pkg;

	localparam int VAE_COORD_BITS = 40;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_CENTER = 2'd1,
		ST_OUTSIDE   = 2'd2
	} status_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_START_STATION = 3'd0,
		REG_START_HEIGHT  = 3'd1,
		REG_END_STATION   = 3'd2,
		REG_END_HEIGHT    = 3'd3,
		REG_ARC_RADIUS    = 3'd4,
		REG_CONVEX_MODE   = 3'd5
	} reg_idx_t;

	// center solver status toward the evaluation pipe
	typedef struct packed {
		logic busy;
		logic ok;
	} solve_stat_t;

endpackage

// ===== hdl/vertical_arc_elevation.sv =====
// ----------------------------------------------------------------------------
// vertical_arc_elevation
// Elevation of a circular vertical arc at a query station, fixed point.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                   Payload
// -------   ---------  --------------------------  ---------------------------
// query     in         start & !busy               query_station
// result    out        done (one cycle, no stall)  elevation, status
// config    in         cfg_valid & cfg_ready       cfg_index, cfg_data
//
// One station enters per cycle while busy is low; each accepted station
// passes four front stages, one square root stage per root bit and one
// output stage before its result appears.
// Every config write restarts the center solver; busy stays high during
// the write and while the bit-serial multiply, divide and root of the
// solver run.
// After reset no solve runs; the zero arc reports no center.
// The result side cannot stall, so the pipe never holds.
// ----------------------------------------------------------------------------
module vertical_arc_elevation import vae_pkg::*; #(
	parameter int COORD_BITS = VAE_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// query word
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] query_station,
	// result word
	output logic                         done,
	output logic signed [COORD_BITS-1:0] elevation,
	output logic        [1:0]            status,
	// config write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic        [2:0]            cfg_index,
	input  logic        [COORD_BITS-1:0] cfg_data
);

	localparam int CW  = COORD_BITS;
	localparam int QW  = 2*CW + 2;     // squared quantities
	localparam int DQ  = QW + 2;       // root radicand
	localparam int NR  = CW + 2;       // root bits
	localparam int SR  = NR + 2;       // root remainder
	localparam int XW  = CW + 3;       // doubled center
	localparam int TW  = CW + 4;       // 2*station - cx2
	localparam int MGW = TW - 1;       // its magnitude
	localparam int H   = (MGW + 1) / 2;
	localparam int HW  = MGW - H;
	localparam int TTW = 2*MGW;
	localparam int EW  = CW + 5;       // 4*elevation before rounding

	localparam logic signed [EW-1:0] E_MAX = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [EW-1:0] E_MIN = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	// configuration registers
	logic signed [CW-1:0] start_station_q, start_height_q, end_station_q, end_height_q;
	logic        [CW-1:0] arc_radius_q;
	logic                 convex_mode_q;

	logic                 kick;
	logic                 kick_q;
	logic                 accept;
	solve_stat_t          sv_stat;
	logic signed [XW-1:0] cx2, cy2;
	logic [QW-1:0]        r4;

	assign cfg_ready = 1'b1;
	assign kick      = cfg_valid & cfg_ready;
	assign busy      = sv_stat.busy | cfg_valid | kick_q;
	assign accept    = start & !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_station_q <= '0;
			start_height_q  <= '0;
			end_station_q   <= '0;
			end_height_q    <= '0;
			arc_radius_q    <= '0;
			convex_mode_q   <= 1'b0;
		end else if (kick) begin
			unique case (reg_idx_t'(cfg_index))
				REG_START_STATION: start_station_q <= cfg_data;
				REG_START_HEIGHT:  start_height_q  <= cfg_data;
				REG_END_STATION:   end_station_q   <= cfg_data;
				REG_END_HEIGHT:    end_height_q    <= cfg_data;
				REG_ARC_RADIUS:    arc_radius_q    <= cfg_data;
				REG_CONVEX_MODE:   convex_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// solver starts in the cycle after the write, once the registers hold it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kick_q <= 1'b0;
		else
			kick_q <= kick;
	end

	// center is a function of the config alone; solved once per write
	vae_solver #(
		.COORD_BITS (COORD_BITS)
	) u_solver (
		.clk    (clk),
		.arst_n (arst_n),
		.kick   (kick_q),
		.xs     (start_station_q),
		.ys     (start_height_q),
		.xe     (end_station_q),
		.ye     (end_height_q),
		.rad    (arc_radius_q),
		.convex (convex_mode_q),
		.stat   (sv_stat),
		.cx2    (cx2),
		.cy2    (cy2),
		.r4     (r4)
	);

	// ---- stage 1: arc range check, offset from center ----------------------
	logic                 v_s1;
	status_t              st_s1;
	logic signed [TW-1:0] t2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		t2_s1 <= (TW'(query_station) <<< 1) - TW'(cx2);
		// outside the arc wins over a missing center
		if (query_station < start_station_q || query_station > end_station_q)
			st_s1 <= ST_OUTSIDE;
		else if (!sv_stat.ok)
			st_s1 <= ST_NO_CENTER;
		else
			st_s1 <= ST_OK;
	end

	// ---- stage 2: split square into partial products -----------------------
	logic [MGW-1:0]      mag_c;
	logic                v_s2;
	status_t             st_s2;
	logic [2*HW-1:0]     hh_s2;
	logic [HW+H-1:0]     hl_s2;
	logic [2*H-1:0]      ll_s2;

	assign mag_c = t2_s1[TW-1] ? MGW'(-t2_s1) : MGW'(t2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		st_s2 <= st_s1;
		hh_s2 <= mag_c[MGW-1:H] * mag_c[MGW-1:H];
		hl_s2 <= mag_c[MGW-1:H] * mag_c[H-1:0];
		ll_s2 <= mag_c[H-1:0] * mag_c[H-1:0];
	end

	// ---- stage 3: sum partial products -------------------------------------
	logic           v_s3;
	status_t        st_s3;
	logic [TTW-1:0] tt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		st_s3 <= st_s2;
		tt_s3 <= (TTW'(hh_s2) << (2*H)) + (TTW'(hl_s2) << (H+1)) + TTW'(ll_s2);
	end

	// ---- stage 4: circle check, radicand 4*(4r^2 - t2^2) -------------------
	logic          v_s4;
	status_t       st_s4;
	logic [DQ-1:0] rad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		st_s4  <= st_s3;
		rad_s4 <= {QW'(r4 - tt_s3[QW-1:0]), 2'b00};
		if (st_s3 == ST_OK) begin
			if (tt_s3 > TTW'(r4))
				st_s4 <= ST_OUTSIDE;
		end
	end

	// ---- stages 5 .. 4+NR: one root bit per stage --------------------------
	logic          sq_v_s5   [NR];
	status_t       sq_st_s5  [NR];
	logic [SR-1:0] sq_sr_s5  [NR];
	logic [NR-1:0] sq_rt_s5  [NR];
	logic [DQ-1:0] sq_src_s5 [NR];

	for (genvar k = 0; k < NR; k++) begin : g_root
		logic          in_v;
		status_t       in_st;
		logic [SR-1:0] in_sr;
		logic [NR-1:0] in_rt;
		logic [DQ-1:0] in_src;
		logic [SR+1:0] t, trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign in_v   = v_s4;
			assign in_st  = st_s4;
			assign in_sr  = '0;
			assign in_rt  = '0;
			assign in_src = rad_s4;
		end else begin : g_next
			assign in_v   = sq_v_s5[k-1];
			assign in_st  = sq_st_s5[k-1];
			assign in_sr  = sq_sr_s5[k-1];
			assign in_rt  = sq_rt_s5[k-1];
			assign in_src = sq_src_s5[k-1];
		end

		assign t     = {in_sr, in_src[DQ-1:DQ-2]};
		assign trial = (SR+2)'({in_rt, 2'b01});
		assign ge    = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s5[k] <= 1'b0;
			else
				sq_v_s5[k] <= in_v;
		end

		always_ff @(posedge clk) begin
			sq_st_s5[k]  <= in_st;
			sq_sr_s5[k]  <= ge ? SR'(t - trial) : t[SR-1:0];
			sq_rt_s5[k]  <= {in_rt[NR-2:0], ge};
			sq_src_s5[k] <= in_src << 2;
		end
	end

	// ---- output stage: combine, round half up, saturate --------------------
	logic signed [EW-1:0] e4_c, e4r_c, sh_c;
	logic [CW-1:0]        sat_c;
	logic                 done_q;
	logic [CW-1:0]        elevation_q;
	status_t              status_q;

	always_comb begin
		if (convex_mode_q)
			e4_c = (EW'(cy2) <<< 1) - signed'(EW'(sq_rt_s5[NR-1]));
		else
			e4_c = (EW'(cy2) <<< 1) + signed'(EW'(sq_rt_s5[NR-1]));
		e4r_c = e4_c + EW'(2);
		sh_c  = e4r_c >>> 2;
		if (sh_c > E_MAX)
			sat_c = E_MAX[CW-1:0];
		else if (sh_c < E_MIN)
			sat_c = E_MIN[CW-1:0];
		else
			sat_c = sh_c[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= sq_v_s5[NR-1];
	end

	always_ff @(posedge clk) begin
		status_q    <= sq_st_s5[NR-1];
		elevation_q <= (sq_st_s5[NR-1] == ST_OK) ? sat_c : '0;
	end

	assign done      = done_q;
	assign elevation = elevation_q;
	assign status    = status_q;

`ifndef ASSERT_OFF
	// fixed latency: every accepted station yields exactly one word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(NR+5) done)
		else $error("result missing at fixed latency");

	// error words carry a zero elevation
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (elevation == '0))
		else $error("nonzero elevation on error status");

	// a config write holds off queries while the center is resolved
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		kick |=> busy)
		else $error("not busy after config write");
`endif

endmodule

// ===== hdl/vae_solver.sv =====
// ----------------------------------------------------------------------------
// vae_solver
// Sequential center solver: finds the doubled arc center from the
// configured end points and radius with a bit-serial multiplier, a
// restoring divider and a digit-by-digit square root.
// ----------------------------------------------------------------------------
module vae_solver import vae_pkg::*; #(
	parameter int COORD_BITS = VAE_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         kick,
	input  logic signed [COORD_BITS-1:0] xs,
	input  logic signed [COORD_BITS-1:0] ys,
	input  logic signed [COORD_BITS-1:0] xe,
	input  logic signed [COORD_BITS-1:0] ye,
	input  logic        [COORD_BITS-1:0] rad,
	input  logic                         convex,
	output solve_stat_t                  stat,
	output logic signed [COORD_BITS+2:0] cx2,
	output logic signed [COORD_BITS+2:0] cy2,
	output logic    [2*COORD_BITS+1:0]   r4
);

	localparam int CW   = COORD_BITS;
	localparam int QW   = 2*CW + 2;
	localparam int DQ   = QW + 2;
	localparam int NR   = CW + 2;
	localparam int SR   = NR + 2;
	localparam int XW   = CW + 3;
	localparam int CNTW = $clog2(DQ);

	typedef enum logic [6:0] {
		SV_IDLE = 7'b0000001,
		SV_SQR  = 7'b0000010,
		SV_CHK  = 7'b0000100,
		SV_MUL  = 7'b0001000,
		SV_DIV  = 7'b0010000,
		SV_ROOT = 7'b0100000,
		SV_FIN  = 7'b1000000
	} sv_state_t;

	typedef enum logic [1:0] {
		SQ_R  = 2'd0,
		SQ_DX = 2'd1,
		SQ_DY = 2'd2
	} sq_sel_t;

	sv_state_t state_q;
	sq_sel_t   sel_q;
	logic                 ok_q;
	logic                 second_q;
	logic [QW-1:0]        ma_q, mb_q;
	logic [2*QW-1:0]      prod_q;
	logic [CNTW-1:0]      cnt_q;
	logic [QW-1:0]        r4_q, dx2_q, dy2_q, d2_q, s_q;
	logic [QW-1:0]        dr_q;
	logic [DQ-1:0]        dq_q;
	logic [SR-1:0]        sr_q;
	logic [NR-1:0]        root_q, gox_q, goy_q;
	logic signed [XW-1:0] cx2_q, cy2_q;

	logic signed [CW:0]   dx, dy;
	logic [CW:0]          mdx, mdy;
	logic [QW:0]          msum;
	logic [2*QW-1:0]      mul_nx;
	logic [QW-1:0]        d2_sum;
	logic [QW:0]          dv_t;
	logic                 dv_ge;
	logic [QW-1:0]        dr_nx;
	logic [SR+1:0]        rt_t, rt_trial;
	logic                 rt_ge;
	logic [SR-1:0]        sr_nx;
	logic [NR-1:0]        root_nx;
	logic [NR:0]          g_inc;
	logic [NR-1:0]        g_nx;
	logic signed [XW-1:0] sumx, sumy, gxv, gyv;
	logic                 dx_pos;

	always_comb begin
		dx     = (CW+1)'(xe) - (CW+1)'(xs);
		dy     = (CW+1)'(ye) - (CW+1)'(ys);
		mdx    = dx[CW] ? (~dx + 1'b1) : dx;
		mdy    = dy[CW] ? (~dy + 1'b1) : dy;
		msum   = {1'b0, prod_q[2*QW-1:QW]} + (ma_q[0] ? {1'b0, mb_q} : '0);
		mul_nx = {msum, prod_q[QW-1:1]};
		d2_sum = dx2_q + dy2_q;
		// restoring divide step
		dv_t   = {dr_q, dq_q[DQ-1]};
		dv_ge  = dv_t >= {1'b0, d2_q};
		dr_nx  = dv_ge ? QW'(dv_t - {1'b0, d2_q}) : dv_t[QW-1:0];
		// square root step
		rt_t     = {sr_q, dq_q[DQ-1:DQ-2]};
		rt_trial = (SR+2)'({root_q, 2'b01});
		rt_ge    = rt_t >= rt_trial;
		sr_nx    = rt_ge ? SR'(rt_t - rt_trial) : rt_t[SR-1:0];
		root_nx  = {root_q[NR-2:0], rt_ge};
		g_inc    = (NR+1)'(root_nx) + 1'b1;
		g_nx     = g_inc[NR:1];
		// doubled center
		sumx   = XW'(xs) + XW'(xe);
		sumy   = XW'(ys) + XW'(ye);
		gxv    = dy[CW] ? -signed'(XW'(gox_q)) : signed'(XW'(gox_q));
		gyv    = signed'(XW'(goy_q));
		dx_pos = !dx[CW] && (dx != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SV_IDLE;
			ok_q    <= 1'b0;
		end else if (kick) begin
			state_q <= SV_SQR;
			ok_q    <= 1'b0;
		end else begin
			unique case (state_q)
				SV_IDLE: ;
				SV_SQR: begin
					if (cnt_q == CNTW'(QW-1) && sel_q == SQ_DY)
						state_q <= SV_CHK;
				end
				SV_CHK: begin
					if (d2_sum == '0 || d2_sum > r4_q)
						state_q <= SV_IDLE;
					else
						state_q <= SV_MUL;
				end
				SV_MUL: begin
					if (cnt_q == CNTW'(QW-1))
						state_q <= SV_DIV;
				end
				SV_DIV: begin
					if (cnt_q == CNTW'(DQ-1))
						state_q <= SV_ROOT;
				end
				SV_ROOT: begin
					if (cnt_q == CNTW'(NR-1))
						state_q <= second_q ? SV_FIN : SV_MUL;
				end
				SV_FIN: begin
					state_q <= SV_IDLE;
					ok_q    <= 1'b1;
				end
				default: state_q <= SV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (kick) begin
			sel_q  <= SQ_R;
			ma_q   <= QW'(rad);
			mb_q   <= QW'(rad);
			prod_q <= '0;
			cnt_q  <= '0;
		end else begin
			case (state_q)
				SV_SQR: begin
					prod_q <= mul_nx;
					ma_q   <= ma_q >> 1;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(QW-1)) begin
						cnt_q  <= '0;
						prod_q <= '0;
						case (sel_q)
							SQ_R: begin
								r4_q  <= {mul_nx[QW-3:0], 2'b00};
								sel_q <= SQ_DX;
								ma_q  <= QW'(mdx);
								mb_q  <= QW'(mdx);
							end
							SQ_DX: begin
								dx2_q <= mul_nx[QW-1:0];
								sel_q <= SQ_DY;
								ma_q  <= QW'(mdy);
								mb_q  <= QW'(mdy);
							end
							default: dy2_q <= mul_nx[QW-1:0];
						endcase
					end
				end
				SV_CHK: begin
					d2_q     <= d2_sum;
					s_q      <= r4_q - d2_sum;
					ma_q     <= dy2_q;
					mb_q     <= r4_q - d2_sum;
					prod_q   <= '0;
					cnt_q    <= '0;
					second_q <= 1'b0;
				end
				SV_MUL: begin
					prod_q <= mul_nx;
					ma_q   <= ma_q >> 1;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(QW-1)) begin
						cnt_q <= '0;
						// dividend is product * 4; preload its top part
						dr_q  <= mul_nx[2*QW-1:QW];
						dq_q  <= {mul_nx[QW-1:0], 2'b00};
					end
				end
				SV_DIV: begin
					dr_q  <= dr_nx;
					dq_q  <= {dq_q[DQ-2:0], dv_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(DQ-1)) begin
						cnt_q  <= '0;
						sr_q   <= '0;
						root_q <= '0;
					end
				end
				SV_ROOT: begin
					sr_q   <= sr_nx;
					root_q <= root_nx;
					dq_q   <= dq_q << 2;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(NR-1)) begin
						cnt_q <= '0;
						if (!second_q) begin
							gox_q    <= g_nx;
							second_q <= 1'b1;
							ma_q     <= dx2_q;
							mb_q     <= s_q;
							prod_q   <= '0;
						end else begin
							goy_q <= g_nx;
						end
					end
				end
				SV_FIN: begin
					cx2_q <= (!convex && dx_pos) ? sumx + gxv : sumx - gxv;
					cy2_q <= convex ? sumy + gyv : sumy - gyv;
				end
				default: ;
			endcase
		end
	end

	assign stat.busy = (state_q != SV_IDLE);
	assign stat.ok   = ok_q;
	assign cx2       = cx2_q;
	assign cy2       = cy2_q;
	assign r4        = r4_q;

endmodule
